[rtl/core/tbb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tbb_pkg;

  localparam int ACCEL_W = 20;
  localparam int CORR_W  = ACCEL_W + 1;   // reading minus offset
  localparam int DT_W    = 8;
  localparam int MAXS_W  = 20;
  localparam int SPEED_W = MAXS_W + 1;    // speed stays within +-max_speed
  localparam int LIM_W   = 11;
  localparam int BALL_W  = 19;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_MAX_SPEED,
    CFG_ORIENTATION,
    CFG_OFFSET_X,
    CFG_OFFSET_Y,
    CFG_LEFT_LIMIT,
    CFG_RIGHT_LIMIT,
    CFG_TOP_LIMIT,
    CFG_BOTTOM_LIMIT
  } tbb_cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_ADD,
    ST_CLAMP,
    ST_MUL_V,
    ST_MUL_R,
    ST_MOVE,
    ST_BOUNCE,
    ST_DONE
  } tbb_state_t;

  // One strobe per lane step, driven by the sequencer
  typedef struct packed {
    logic mul_a;
    logic add;
    logic clamp;
    logic mul_v;
    logic mul_r;
    logic move;
    logic bounce;
  } tbb_step_t;

endpackage

`default_nettype wire

[rtl/core/tbb_axis.sv]
`timescale 1ns / 1ps
`default_nettype none

module tbb_axis import tbb_pkg::*; #(
  parameter int POS_FRAC_BITS = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire tbb_step_t                           step,
  input  wire logic signed [CORR_W-1:0]            accel,
  input  wire logic        [DT_W-1:0]              elapsed,
  input  wire logic                                flip,
  input  wire logic        [MAXS_W-1:0]            max_speed,
  input  wire logic        [LIM_W-1:0]             lo_limit,
  input  wire logic        [LIM_W-1:0]             hi_limit,
  output logic             [LIM_W+POS_FRAC_BITS-1:0] pos,
  output logic                                     changed
);

  localparam int PW     = LIM_W + POS_FRAC_BITS;
  localparam int PROD_W = CORR_W + DT_W + 1;
  localparam int SUM_W  = SPEED_W + 2;
  localparam int VMAG_W = MAXS_W + DT_W;
  localparam int Q_W    = 19;                      // speed*dt/1000 < 2^19
  localparam int NW     = ((PW > Q_W) ? PW : Q_W) + 2;
  localparam int RSH    = 38;                      // 2^38/1000 reciprocal
  localparam int RM_W   = 29;
  localparam logic [RM_W-1:0] DIV1000_MUL = 29'd274877907;
  localparam int RP_W   = VMAG_W + RM_W;

  function automatic logic signed [SPEED_W-1:0] halve_neg(
    input logic signed [SPEED_W-1:0] s
  );
    logic signed [SPEED_W-1:0] u;
    logic signed [SPEED_W-1:0] t;
    u = s + $signed({{(SPEED_W-1){1'b0}}, s[SPEED_W-1]});
    t = u >>> 1;
    return -t;
  endfunction

  logic signed [PROD_W-1:0]  prod_a;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SPEED_W-1:0] speed;
  logic        [VMAG_W-1:0]  vmag;
  logic                      vneg;
  logic        [Q_W-1:0]     qmag;
  logic signed [NW-1:0]      nx;

  // accel * dt
  logic signed [PROD_W-1:0] acc_ext;
  logic signed [PROD_W-1:0] dt_ext;
  assign acc_ext = PROD_W'(accel);
  assign dt_ext  = $signed({{(PROD_W-DT_W){1'b0}}, elapsed});

  // trunc(prod/65536), negated on flip, * 512, then add to speed
  logic signed [PROD_W-1:0] prod_bias;
  logic signed [12:0]       dv_raw;
  logic signed [12:0]       dv;
  logic signed [21:0]       dv_step;
  assign prod_bias = prod_a + (prod_a[PROD_W-1] ? 30'sd65535 : 30'sd0);
  assign dv_raw    = $signed(prod_bias[28:16]);
  assign dv        = flip ? -dv_raw : dv_raw;
  assign dv_step   = $signed({dv, 9'b0});

  // clamp to +-max_speed
  logic signed [SUM_W-1:0] m_pos;
  logic signed [SUM_W-1:0] m_neg;
  logic signed [SUM_W-1:0] clamp_hi;
  logic signed [SUM_W-1:0] clamp_lo;
  assign m_pos    = $signed({{(SUM_W-MAXS_W){1'b0}}, max_speed});
  assign m_neg    = -m_pos;
  assign clamp_hi = (sum >= m_pos) ? m_pos : sum;
  assign clamp_lo = (clamp_hi <= m_neg) ? m_neg : clamp_hi;

  // |speed| * dt and its reciprocal product
  logic signed [SPEED_W-1:0] speed_abs;
  logic        [RP_W-1:0]    rprod;
  assign speed_abs = speed[SPEED_W-1] ? -speed : speed;
  assign rprod     = RP_W'(vmag) * RP_W'(DIV1000_MUL);

  // new position and box edges
  logic signed [NW-1:0] pos_ext;
  logic signed [NW-1:0] q_ext;
  logic signed [NW-1:0] hip;
  logic signed [NW-1:0] lop;
  logic signed [NW-1:0] p1;
  logic signed [NW-1:0] p2;
  logic signed [SPEED_W-1:0] s1;
  logic signed [SPEED_W-1:0] s2;
  logic hit_hi;
  logic hit_lo;

  assign pos_ext = $signed({{(NW-PW){1'b0}}, pos});
  assign q_ext   = $signed({{(NW-Q_W){1'b0}}, qmag});
  assign hip     = $signed({{(NW-LIM_W){1'b0}}, hi_limit} << POS_FRAC_BITS);
  assign lop     = $signed({{(NW-LIM_W){1'b0}}, lo_limit} << POS_FRAC_BITS);

  // right/bottom before left/top
  always_comb begin
    hit_hi = nx > hip;
    p1     = hit_hi ? hip : nx;
    s1     = hit_hi ? halve_neg(speed) : speed;
    hit_lo = p1 < lop;
    p2     = hit_lo ? lop : p1;
    s2     = hit_lo ? halve_neg(s1) : s1;
  end

  always_ff @(posedge clk) begin
    if (step.mul_a) begin
      prod_a <= acc_ext * dt_ext;
    end
    if (step.add) begin
      sum <= SUM_W'(speed) + SUM_W'(dv_step);
    end
    if (step.mul_v) begin
      vneg <= speed[SPEED_W-1];
      vmag <= VMAG_W'(speed_abs[MAXS_W-1:0]) * VMAG_W'(elapsed);
    end
    if (step.mul_r) begin
      qmag <= rprod[RP_W-1:RSH];
    end
    if (step.move) begin
      nx <= vneg ? (pos_ext - q_ext) : (pos_ext + q_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed   <= '0;
      pos     <= '0;
      changed <= 1'b0;
    end else begin
      if (step.clamp) begin
        speed <= clamp_lo[SPEED_W-1:0];
      end
      if (step.bounce) begin
        speed   <= s2;
        pos     <= p2[PW-1:0];
        changed <= (p2 != pos_ext);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/tbb_out.sv]
`timescale 1ns / 1ps
`default_nettype none

module tbb_out import tbb_pkg::*; #(
  parameter int POS_W = 19
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire logic              motion,
  input  wire logic [POS_W-1:0]  pos_x,
  input  wire logic [POS_W-1:0]  pos_y,
  input  wire logic              chg_x,
  input  wire logic              chg_y,
  input  wire logic              rotate,
  input  wire logic              result_stall,
  output logic                   result_valid,
  output logic                   free,
  output logic [BALL_W-1:0]      ball_x,
  output logic [BALL_W-1:0]      ball_y,
  output logic                   moved,
  output logic                   rotate_request
);

  assign free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // merge the lanes: moved only on a valid reading
  always_ff @(posedge clk) begin
    if (load) begin
      ball_x         <= BALL_W'(pos_x);
      ball_y         <= BALL_W'(pos_y);
      moved          <= motion && (chg_x || chg_y);
      rotate_request <= rotate;
    end
  end

endmodule

`default_nettype wire

[rtl/core/tilt_ball_bounce_step.sv]
`timescale 1ns / 1ps
`default_nettype none

// Tilt ball step: one accelerometer tick in, one ball position out.
// Tick channel: tick_valid/tick_stall with accel_x, accel_y, elapsed_ms and
// reading_ok; a tick is taken when tick_valid is high and tick_stall low.
// Result channel: result_valid/result_stall with ball_x, ball_y, moved and
// rotate_request. Registers are written through cfg_valid/cfg_ready (always
// ready), cfg_index selecting the register, cfg_data carrying the value.
// Two axis lanes run in lockstep through a seven-step sequence (accel
// multiply, speed add, clamp, speed*dt multiply, reciprocal multiply for
// the /1000, move, edge bounce); each multiply has its own step.
// A valid tick passes through every step; its result is registered when the
// output register is free. A tick with reading_ok low skips the lane steps.
// tick_stall is high while a tick is in flight. A finished result sits in
// the output register while result_stall is high; the next tick is taken
// meanwhile, and its result waits in the last step until the register frees.
// Synchronous reset clears speed, position and the rotate flag and loads
// the register defaults; the first valid tick pulls the ball into the box.

module tilt_ball_bounce_step import tbb_pkg::*; #(
  parameter int POS_FRAC_BITS = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     tick_valid,
  output logic                          tick_stall,
  input  wire logic signed [ACCEL_W-1:0] accel_x,
  input  wire logic signed [ACCEL_W-1:0] accel_y,
  input  wire logic [DT_W-1:0]          elapsed_ms,
  input  wire logic                     reading_ok,
  output logic                          result_valid,
  input  wire logic                     result_stall,
  output logic [BALL_W-1:0]             ball_x,
  output logic [BALL_W-1:0]             ball_y,
  output logic                          moved,
  output logic                          rotate_request,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [2:0]               cfg_index,
  input  wire logic [MAXS_W-1:0]        cfg_data
);

  localparam int PW = LIM_W + POS_FRAC_BITS;
  localparam logic signed [ACCEL_W-1:0] ROT_THRESH = 20'sd32768;

  logic [MAXS_W-1:0]         max_speed;
  logic [2:0]                orientation;
  logic signed [ACCEL_W-1:0] offset_x;
  logic signed [ACCEL_W-1:0] offset_y;
  logic [LIM_W-1:0]          left_limit;
  logic [LIM_W-1:0]          right_limit;
  logic [LIM_W-1:0]          top_limit;
  logic [LIM_W-1:0]          bottom_limit;

  tbb_state_t state;
  tbb_state_t state_next;
  tbb_step_t  step;

  logic signed [CORR_W-1:0] corr_x;
  logic signed [CORR_W-1:0] corr_y;
  logic [DT_W-1:0]          dt;
  logic                     ok;
  logic                     rotate_flag;

  logic          tick_take;
  logic          load;
  logic          free;
  logic [PW-1:0] pos_x;
  logic [PW-1:0] pos_y;
  logic          chg_x;
  logic          chg_y;

  assign cfg_ready = 1'b1;
  assign tick_take = tick_valid && !tick_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed    <= 20'd65536;
      orientation  <= 3'd0;
      offset_x     <= '0;
      offset_y     <= '0;
      left_limit   <= 11'd10;
      right_limit  <= 11'd470;
      top_limit    <= 11'd10;
      bottom_limit <= 11'd262;
    end else if (cfg_valid && cfg_ready) begin
      case (tbb_cfg_idx_t'(cfg_index))
        CFG_MAX_SPEED:    max_speed    <= cfg_data;
        CFG_ORIENTATION:  orientation  <= cfg_data[2:0];
        CFG_OFFSET_X:     offset_x     <= $signed(cfg_data);
        CFG_OFFSET_Y:     offset_y     <= $signed(cfg_data);
        CFG_LEFT_LIMIT:   left_limit   <= cfg_data[LIM_W-1:0];
        CFG_RIGHT_LIMIT:  right_limit  <= cfg_data[LIM_W-1:0];
        CFG_TOP_LIMIT:    top_limit    <= cfg_data[LIM_W-1:0];
        CFG_BOTTOM_LIMIT: bottom_limit <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // capture the tick with offsets removed
  always_ff @(posedge clk) begin
    if (tick_take) begin
      corr_x <= CORR_W'(accel_x) - CORR_W'(offset_x);
      corr_y <= CORR_W'(accel_y) - CORR_W'(offset_y);
      dt     <= elapsed_ms;
      ok     <= reading_ok;
    end
  end

  // rotate flag follows the raw reading on every tick
  always_ff @(posedge clk) begin
    if (rst) begin
      rotate_flag <= 1'b0;
    end else if (tick_take) begin
      if (accel_x > ROT_THRESH) begin
        rotate_flag <= 1'b1;
      end else if (accel_y > ROT_THRESH) begin
        rotate_flag <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    step       = '0;
    tick_stall = 1'b1;
    load       = 1'b0;
    case (state)
      ST_IDLE: begin
        tick_stall = 1'b0;
        if (tick_valid) begin
          state_next = reading_ok ? ST_MUL_A : ST_DONE;
        end
      end
      ST_MUL_A: begin
        step.mul_a = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        step.add   = 1'b1;
        state_next = ST_CLAMP;
      end
      ST_CLAMP: begin
        step.clamp = 1'b1;
        state_next = ST_MUL_V;
      end
      ST_MUL_V: begin
        step.mul_v = 1'b1;
        state_next = ST_MUL_R;
      end
      ST_MUL_R: begin
        step.mul_r = 1'b1;
        state_next = ST_MOVE;
      end
      ST_MOVE: begin
        step.move  = 1'b1;
        state_next = ST_BOUNCE;
      end
      ST_BOUNCE: begin
        step.bounce = 1'b1;
        state_next  = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register can take the result
        if (free) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  tbb_axis #(
    .POS_FRAC_BITS (POS_FRAC_BITS)
  ) u_lane_x (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .accel     (orientation[0] ? corr_y : corr_x),
    .elapsed   (dt),
    .flip      (orientation[1]),
    .max_speed (max_speed),
    .lo_limit  (left_limit),
    .hi_limit  (right_limit),
    .pos       (pos_x),
    .changed   (chg_x)
  );

  tbb_axis #(
    .POS_FRAC_BITS (POS_FRAC_BITS)
  ) u_lane_y (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .accel     (orientation[0] ? corr_x : corr_y),
    .elapsed   (dt),
    .flip      (orientation[2]),
    .max_speed (max_speed),
    .lo_limit  (top_limit),
    .hi_limit  (bottom_limit),
    .pos       (pos_y),
    .changed   (chg_y)
  );

  tbb_out #(
    .POS_W (PW)
  ) u_out (
    .clk            (clk),
    .rst            (rst),
    .load           (load),
    .motion         (ok),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .chg_x          (chg_x),
    .chg_y          (chg_y),
    .rotate         (rotate_flag),
    .result_stall   (result_stall),
    .result_valid   (result_valid),
    .free           (free),
    .ball_x         (ball_x),
    .ball_y         (ball_y),
    .moved          (moved),
    .rotate_request (rotate_request)
  );

endmodule

`default_nettype wire

[sim/tilt_ball_bounce_step_tb.sv]
`timescale 1ns / 1ps

module tilt_ball_bounce_step_tb;
  import tbb_pkg::*;

  localparam int POS_FRAC    = 8;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES      = 8;
  localparam int PHASE_TICKS = 205;

  typedef struct packed {
    logic signed [ACCEL_W-1:0] ax;
    logic signed [ACCEL_W-1:0] ay;
    logic [DT_W-1:0]           dt;
    logic                      ok;
  } tick_t;

  typedef struct packed {
    logic [BALL_W-1:0] x;
    logic [BALL_W-1:0] y;
    logic              moved;
    logic              rot;
  } ball_t;

  typedef enum int {STALL_NONE, STALL_HALF, STALL_SPARSE, STALL_PERIODIC} stall_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic tick_valid = 1'b0;
  logic tick_stall;
  logic signed [ACCEL_W-1:0] accel_x = '0;
  logic signed [ACCEL_W-1:0] accel_y = '0;
  logic [DT_W-1:0] elapsed_ms = '0;
  logic reading_ok = 1'b0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [BALL_W-1:0] ball_x;
  logic [BALL_W-1:0] ball_y;
  logic moved;
  logic rotate_request;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [MAXS_W-1:0] cfg_data = '0;

  tilt_ball_bounce_step #(.POS_FRAC_BITS(POS_FRAC)) dut (
    .clk(clk), .rst(rst),
    .tick_valid(tick_valid), .tick_stall(tick_stall),
    .accel_x(accel_x), .accel_y(accel_y), .elapsed_ms(elapsed_ms), .reading_ok(reading_ok),
    .result_valid(result_valid), .result_stall(result_stall),
    .ball_x(ball_x), .ball_y(ball_y), .moved(moved), .rotate_request(rotate_request),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Ball physics state and register copy
  longint speed_x_q, speed_y_q, pos_x_q, pos_y_q;
  bit rotate_q;
  longint max_speed_q, off_x_q, off_y_q;
  logic [2:0] orient_q;
  longint left_q, right_q, top_q, bottom_q;

  tick_t pending_ticks[$];
  ball_t expected_balls[$];

  int errors = 0;
  int ticks_taken = 0;
  int dropped_ticks = 0;
  int moved_results = 0;
  int rotate_changes = 0;
  int long_holds = 0;
  bit last_rot = 1'b0;

  function automatic longint clamp_speed(longint s);
    if (s >= max_speed_q) s = max_speed_q;
    if (s <= -max_speed_q) s = -max_speed_q;
    return s;
  endfunction

  // Right/bottom edge checked first; inverted limits can fire both checks
  function automatic void bounce_axis(inout longint p, inout longint s, input longint lo,
                                      input longint hi);
    longint hip, lop;
    hip = hi << POS_FRAC;
    lop = lo << POS_FRAC;
    if (p > hip) begin
      p = hip;
      s = -(s / 2);
    end
    if (p < lop) begin
      p = lop;
      s = -(s / 2);
    end
  endfunction

  function automatic ball_t advance_ball(tick_t t);
    longint ax, ay, dt, cx, cy, dx, dy, nx, ny;
    ball_t r;
    ax = longint'(t.ax);
    ay = longint'(t.ay);
    dt = longint'(t.dt);
    r.moved = 1'b0;
    if (ax > 32768) rotate_q = 1'b1;
    else if (ay > 32768) rotate_q = 1'b0;
    if (t.ok) begin
      cx = ax - off_x_q;
      cy = ay - off_y_q;
      if (orient_q[0]) begin
        dx = (cy * dt) / 65536;
        dy = (cx * dt) / 65536;
      end else begin
        dx = (cx * dt) / 65536;
        dy = (cy * dt) / 65536;
      end
      if (orient_q[1]) dx = -dx;
      if (orient_q[2]) dy = -dy;
      speed_x_q = clamp_speed(speed_x_q + dx * 512);
      speed_y_q = clamp_speed(speed_y_q + dy * 512);
      nx = pos_x_q + (speed_x_q * dt) / 1000;
      ny = pos_y_q + (speed_y_q * dt) / 1000;
      bounce_axis(nx, speed_x_q, left_q, right_q);
      bounce_axis(ny, speed_y_q, top_q, bottom_q);
      if (nx != pos_x_q || ny != pos_y_q) begin
        r.moved = 1'b1;
        pos_x_q = nx;
        pos_y_q = ny;
      end
    end
    r.x = pos_x_q[BALL_W-1:0];
    r.y = pos_y_q[BALL_W-1:0];
    r.rot = rotate_q;
    return r;
  endfunction

  function automatic void queue_tick(int ax, int ay, int dt, bit ok);
    tick_t t;
    t.ax = ax[ACCEL_W-1:0];
    t.ay = ay[ACCEL_W-1:0];
    t.dt = dt[DT_W-1:0];
    t.ok = ok;
    pending_ticks.push_back(t);
  endfunction

  function automatic int random_accel();
    int v;
    case ($urandom_range(0, 9))
      0, 1: v = $urandom_range(0, 1048575) - 524288;
      2: v = 32768 + $urandom_range(0, 4) - 2;
      default: v = $urandom_range(0, 262143) - 131072;
    endcase
    return v;
  endfunction

  function automatic void queue_random_tick();
    int dt;
    case ($urandom_range(0, 9))
      0: dt = 0;
      1: dt = 255;
      2: dt = $urandom_range(0, 255);
      default: dt = $urandom_range(1, 40);
    endcase
    queue_tick(random_accel(), random_accel(), dt, $urandom_range(0, 99) < 88);
  endfunction

  // Driver: bursts of requests with random gaps, fed from pending_ticks
  int burst_left = 0;
  int gap_left = 0;
  tick_t next_tick;

  always @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else begin
      if (tick_valid && !tick_stall) begin
        expected_balls.push_back(advance_ball({accel_x, accel_y, elapsed_ms, reading_ok}));
        ticks_taken++;
        if (!reading_ok) dropped_ticks++;
      end
      if (!tick_valid || !tick_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          tick_valid <= 1'b0;
        end else if (pending_ticks.size() > 0) begin
          next_tick = pending_ticks.pop_front();
          accel_x <= next_tick.ax;
          accel_y <= next_tick.ay;
          elapsed_ms <= next_tick.dt;
          reading_ok <= next_tick.ok;
          tick_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          tick_valid <= 1'b0;
        end
      end
    end
  end

  // Result stall pattern, with long hold-offs to back up the tick channel
  stall_mode_t stall_mode = STALL_NONE;
  int mode_left = 0;
  int hold_left = 0;
  int next_hold_at = 400;

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (hold_left == 0 && ticks_taken >= next_hold_at) begin
        hold_left = $urandom_range(200, 320);
        next_hold_at += 700;
        long_holds++;
      end
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 256);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        case (stall_mode)
          STALL_NONE: result_stall <= 1'b0;
          STALL_HALF: result_stall <= ($urandom_range(0, 1) == 1);
          STALL_SPARSE: result_stall <= ($urandom_range(0, 7) == 0);
          default: result_stall <= ((mode_left % 5) < 2);
        endcase
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation
  ball_t want;

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_balls.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d moved=%0b rot=%0b", $time, ball_x,
                 ball_y, moved, rotate_request);
        errors++;
      end else begin
        want = expected_balls.pop_front();
        if (ball_x !== want.x) begin
          $display("%0t: ball_x expected %0d actual %0d", $time, want.x, ball_x);
          errors++;
        end
        if (ball_y !== want.y) begin
          $display("%0t: ball_y expected %0d actual %0d", $time, want.y, ball_y);
          errors++;
        end
        if (moved !== want.moved) begin
          $display("%0t: moved expected %0b actual %0b", $time, want.moved, moved);
          errors++;
        end
        if (rotate_request !== want.rot) begin
          $display("%0t: rotate_request expected %0b actual %0b", $time, want.rot,
                   rotate_request);
          errors++;
        end
        if (want.moved) moved_results++;
        if (want.rot != last_rot) rotate_changes++;
        last_rot = want.rot;
      end
    end
  end

  int cycles = 0;

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles,
             expected_balls.size());
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic write_reg(tbb_cfg_idx_t idx, logic [MAXS_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MAX_SPEED: max_speed_q = longint'(val);
      CFG_ORIENTATION: orient_q = val[2:0];
      CFG_OFFSET_X: off_x_q = longint'($signed(val));
      CFG_OFFSET_Y: off_y_q = longint'($signed(val));
      CFG_LEFT_LIMIT: left_q = longint'(val[LIM_W-1:0]);
      CFG_RIGHT_LIMIT: right_q = longint'(val[LIM_W-1:0]);
      CFG_TOP_LIMIT: top_q = longint'(val[LIM_W-1:0]);
      default: bottom_q = longint'(val[LIM_W-1:0]);
    endcase
  endtask

  // Hold until every queued request is taken and every result is back
  task automatic drain();
    while (pending_ticks.size() != 0 || tick_valid || expected_balls.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  logic [MAXS_W-1:0] regs[8];
  int lo_x, hi_x, lo_y, hi_y;

  initial begin
    speed_x_q = 0; speed_y_q = 0; pos_x_q = 0; pos_y_q = 0; rotate_q = 1'b0;
    max_speed_q = 65536; orient_q = '0; off_x_q = 0; off_y_q = 0;
    left_q = 10; right_q = 470; top_q = 10; bottom_q = 262;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reading before any valid one: rotation set, ball still at the origin
    queue_tick(40000, 0, 100, 1'b0);
    // No elapsed time, yet the box clamp pulls the ball in
    queue_tick(0, 0, 0, 1'b1);
    // X at the threshold does not set; Y above it clears
    queue_tick(32768, 32769, 0, 1'b1);
    // Both above threshold: X wins
    queue_tick(32769, 40000, 10, 1'b1);
    queue_tick(524287, 524287, 255, 1'b1);
    queue_tick(-524288, -524288, 255, 1'b1);
    // Push into the right and top walls
    repeat (8) queue_tick(300000, -300000, 200, 1'b1);
    // Failed reading still clears rotation, position holds
    queue_tick(0, 524287, 255, 1'b0);
    queue_tick(-1, 1, 255, 1'b1);
    // Push into the left and bottom walls
    repeat (6) queue_tick(-524288, 524287, 255, 1'b1);
    queue_tick(0, 0, 255, 1'b1);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        case (p)
          1: regs = '{20'd0, 20'd0, 20'h80000, 20'h7FFFF, 20'd0, 20'd0, 20'd0, 20'd0};
          // Inverted boxes: low limit above high limit
          2: regs = '{20'hFFFFF, 20'd0, 20'd0, 20'd0, 20'd2047, 20'd0, 20'd100, 20'd50};
          3: regs = '{20'hFFFFF, 20'd0, 20'h7FFFF, 20'h80000, 20'd0, 20'd2047, 20'd0,
                      20'd2047};
          default: begin
            lo_x = $urandom_range(0, 1200);
            hi_x = lo_x + $urandom_range(0, 847);
            lo_y = $urandom_range(0, 1200);
            hi_y = lo_y + $urandom_range(0, 847);
            if ($urandom_range(0, 5) == 0) begin
              lo_x = hi_x + $urandom_range(1, 10);
            end
            regs[0] = ($urandom_range(0, 3) == 0) ? MAXS_W'($urandom_range(0, 1048575))
                                                   : MAXS_W'($urandom_range(1000, 200000));
            regs[2] = MAXS_W'($urandom_range(0, 10000) - 5000);
            regs[3] = MAXS_W'($urandom_range(0, 10000) - 5000);
            regs[4] = MAXS_W'(lo_x[LIM_W-1:0]);
            regs[5] = MAXS_W'(hi_x[LIM_W-1:0]);
            regs[6] = MAXS_W'(lo_y[LIM_W-1:0]);
            regs[7] = MAXS_W'(hi_y[LIM_W-1:0]);
          end
        endcase
        regs[1] = MAXS_W'(p);
        for (int i = 0; i < 8; i++) write_reg(tbb_cfg_idx_t'(i), regs[i]);
      end
      repeat (PHASE_TICKS) queue_random_tick();
      drain();
    end

    errors += expected_balls.size();
    $display("%0d ticks over %0d register settings, %0d without a valid reading;",
             ticks_taken, PHASES, dropped_ticks);
    $display("%0d results moved the ball, %0d rotate flips, %0d long result hold-offs",
             moved_results, rotate_changes, long_holds);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/tbb_pkg.sv
rtl/core/tbb_axis.sv
rtl/core/tbb_out.sv
rtl/core/tilt_ball_bounce_step.sv
sim/tilt_ball_bounce_step_tb.sv
